### hdl/ils_pkg.sv
// Types and constants shared by the indexed list store modules.
`default_nettype none

package ils_pkg;

    // Field widths of the request and result transfers.
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Operation codes.
    localparam logic [KIND_W-1:0] K_READ      = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] K_INS_END   = 3'd2;
    localparam logic [KIND_W-1:0] K_INS_POS   = 3'd3;
    localparam logic [KIND_W-1:0] K_DELETE    = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Request payload.
    typedef struct packed {
        logic        [KIND_W-1:0] kind;
        logic        [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] item_value;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic        [STAT_W-1:0]  status;
        logic signed [DATA_W-1:0]  read_value;
        logic        [COUNT_W-1:0] entry_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

### hdl/ils_ctrl.sv
// Controller state machine that sequences one request at a time.
`default_nettype none

module ils_ctrl
    import ils_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output ctrl_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Handshake outputs and datapath commands.
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_RESP);
    assign cmd.load = s_valid && s_ready;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

`default_nettype wire

### hdl/ils_datapath.sv
// Datapath: request register, row of entry cells, count and result register.
`default_nettype none

module ils_datapath
    import ils_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_cmd_t  cmd,
    input  wire req_t       req,
    output rsp_t            rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = (CW > POS_W) ? CW : POS_W;
    localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    // Request register, loaded on the input transfer.
    logic        [KIND_W-1:0] kind_reg;
    logic        [POS_W-1:0]  pos_reg;
    logic signed [DATA_W-1:0] val_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= req.kind;
            pos_reg  <= req.position;
            val_reg  <= req.item_value;
        end
    end

    // Entry cells and count.
    logic signed [DATA_W-1:0] cell_reg [CAPACITY];
    logic        [CW-1:0]     count_reg;
    logic        [CW-1:0]     count_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] ins_x;
    logic          full;
    logic          do_ins;
    logic          do_del;
    logic signed [DATA_W-1:0] rd_sel;

    assign cnt_x = XW'(count_reg);
    assign pos_x = XW'(pos_reg);
    assign full  = (cnt_x == XW'(CAPACITY));

    // Insert position for the three insert kinds.
    always_comb begin
        unique case (kind_reg)
            K_INS_FRONT: ins_x = '0;
            K_INS_END:   ins_x = cnt_x;
            default:     ins_x = pos_x;
        endcase
    end

    // Read selection over the cells that a position can address.
    always_comb begin
        rd_sel = '0;
        for (int j = 0; j < RD_N; j++) begin
            if (pos_reg == POS_W'(j)) begin
                rd_sel = cell_reg[j];
            end
        end
    end

    // Operation decode, status and result.
    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        rsp_next = '0;
        unique case (kind_reg)
            K_READ: begin
                if (pos_x < cnt_x) begin
                    rsp_next.read_value = rd_sel;
                end else begin
                    rsp_next.status = ST_RANGE;
                end
            end
            K_INS_FRONT, K_INS_END, K_INS_POS: begin
                if (ins_x > cnt_x) begin
                    rsp_next.status = ST_RANGE;
                end else if (full) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            K_DELETE: begin
                if (pos_x < cnt_x) begin
                    do_del = 1'b1;
                end else begin
                    rsp_next.status = ST_RANGE;
                end
            end
            default: begin
                rsp_next.status = ST_RANGE;
            end
        endcase
        if (rsp_next.status == ST_RANGE) begin
            rsp_next.read_value = '1;
        end
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_del) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
        rsp_next.entry_count = COUNT_W'(count_next);
    end

    // Count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // Each cell takes its lower neighbor on an insert above the insert
    // point, the new value at the insert point, and its upper neighbor on
    // a delete at or above the delete point.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] below;
        logic signed [DATA_W-1:0] above;
        logic                     take_below;
        logic                     take_above;

        if (i > 0) begin : g_below
            assign below = cell_reg[i-1];
        end else begin : g_nobelow
            assign below = '0;
        end

        if (i + 1 < CAPACITY) begin : g_above
            assign above = cell_reg[i+1];
        end else begin : g_noabove
            assign above = '0;
        end

        assign take_below = (XW'(i) > ins_x) && (XW'(i) <= cnt_x);
        assign take_above = (XW'(i) >= pos_x) && (XW'(i + 1) < cnt_x);

        always_ff @(posedge aclk) begin
            if (cmd.exec && do_ins) begin
                if (XW'(i) == ins_x) begin
                    cell_reg[i] <= val_reg;
                end else if (take_below) begin
                    cell_reg[i] <= below;
                end
            end else if (cmd.exec && do_del && take_above) begin
                cell_reg[i] <= above;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/indexed_list_store.sv
// Top level of the indexed list store.
`default_nettype none

// Indexed list store: keeps an ordered list of up to CAPACITY signed 32-bit
// values and answers every request with one result. Requests read at a
// position, insert at the front, at the end or before a position, or
// delete at a position; later entries move up or down one place together
// across a row of entry cells. A request is taken in the idle state,
// the next cycle performs the operation and loads the result register, and
// the result is then offered until it is taken. One request is in flight at
// a time, as the controller steps through its idle, execute and respond
// states for each request. Reads out of range return -1 with an out-of-range
// status; in-range inserts into a full list are ignored with a full status.
// No clearing pass is needed after reset.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_data
);

    ctrl_cmd_t cmd;

    // Sequencing.
    ils_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Storage and operation logic.
    ils_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .req     (s_data),
        .rsp     (m_data)
    );

endmodule

`default_nettype wire

### hdl/ils_checker.sv
// Port-level checker for the indexed list store and its bind.
`default_nettype none

module ils_checker
    import ils_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire req_t s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire rsp_t m_data
);

    // A result that is not taken stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed before its transfer");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // Only one request is in flight.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("request taken while another is in flight");

    // While a result waits, no new request is taken.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while a result waits");

    // An out-of-range result reads as all ones and the status is a known code.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != ST_RANGE || m_data.read_value == '1)
                    && (m_data.status == ST_DONE || m_data.status == ST_RANGE
                        || m_data.status == ST_FULL))
        else $error("bad status or out-of-range value");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### tb/sv/list_store_checker.sv
// Checker for the indexed list store: predicts every result and compares it with the block.
module list_store_checker
    import ils_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire req_t s_data,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  wire rsp_t m_data,
    output int        fail_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the list held by the block.
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int unsigned              list_len;

    // Results still owed by the block, oldest first.
    rsp_t pending_results [$];
    int   bad_total;
    int   results_seen;

    // Apply one request to the shadow list and return the result it must give.
    function automatic rsp_t apply_request(req_t r);
        rsp_t        res;
        int unsigned at;
        int unsigned i;
        res.status     = ST_DONE;
        res.read_value = '0;
        case (r.kind)
            K_READ: begin
                if (r.position < list_len) begin
                    res.read_value = list_mem[r.position];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            K_INS_FRONT, K_INS_END, K_INS_POS: begin
                if (r.kind == K_INS_FRONT) begin
                    at = 0;
                end else if (r.kind == K_INS_END) begin
                    at = list_len;
                end else begin
                    at = r.position;
                end
                // The position test wins over the full test.
                if (at > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > at; i--) begin
                        list_mem[i] = list_mem[i - 1];
                    end
                    list_mem[at] = r.item_value;
                    list_len++;
                end
            end
            K_DELETE: begin
                if (r.position < list_len) begin
                    for (i = r.position; i + 1 < list_len; i++) begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_len--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
                // Undefined operations leave the list alone.
                res.status = ST_RANGE;
            end
        endcase
        if (res.status == ST_RANGE) begin
            res.read_value = '1;
        end
        res.entry_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    // Match result transfers against the queue, then predict new request transfers.
    always @(posedge aclk) begin : watch_channels
        rsp_t want;
        if (!aresetn) begin
            list_len = 0;
            pending_results.delete();
            bad_total = 0;
            results_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    bad_total++;
                    if (bad_total <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result: status %0d value %0d count %0d",
                                 $realtime, m_data.status, m_data.read_value,
                                 m_data.entry_count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status ||
                        m_data.read_value !== want.read_value ||
                        m_data.entry_count !== want.entry_count) begin
                        bad_total++;
                        if (bad_total <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d wrong: expected status %0d value %0d count %0d, got status %0d value %0d count %0d",
                                     $realtime, results_seen, want.status, want.read_value,
                                     want.entry_count, m_data.status, m_data.read_value,
                                     m_data.entry_count);
                        end
                    end
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_request(s_data));
            end
        end
        fail_count  <= bad_total;
        outstanding <= pending_results.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the indexed list store testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    import ils_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY    = 16;
    localparam int          CLK_PERIOD  = 10;
    localparam int          RANDOM_REQS = 950;
    localparam int          PHASE_LEN   = 80;
    localparam int          HOLD_AT     = 150;
    localparam int          HOLD_CYCLES = 400;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 10;

    // Operation codes that the block does not define.
    localparam logic [KIND_W-1:0] K_UNDEF_FIRST = K_DELETE + 3'd1;
    localparam logic [KIND_W-1:0] K_UNDEF_LAST  = '1;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    int fail_count;
    int outstanding;
    int requests_sent;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    indexed_list_store #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    list_store_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic req_t make_request(logic [KIND_W-1:0] kind, int unsigned pos,
                                          logic [DATA_W-1:0] value);
        req_t r;
        r.kind       = kind;
        r.position   = POS_W'(pos);
        r.item_value = value;
        return r;
    endfunction

    // Random request; fill phases lean on inserts, drain phases on deletes and reads.
    function automatic req_t random_request(bit filling);
        req_t        r;
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        r.item_value = $urandom;
        if ($urandom_range(0, 4) == 0) begin
            r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end else begin
            r.position = POS_W'($urandom_range(0, CAPACITY + 1));
        end
        if (pick < 3) begin
            r.kind = KIND_W'($urandom_range(int'(K_UNDEF_FIRST), int'(K_UNDEF_LAST)));
        end else if (filling) begin
            r.kind = (pick < 28) ? K_INS_FRONT :
                     (pick < 50) ? K_INS_END   :
                     (pick < 75) ? K_INS_POS   :
                     (pick < 88) ? K_READ      : K_DELETE;
        end else begin
            r.kind = (pick < 10) ? K_INS_FRONT :
                     (pick < 18) ? K_INS_END   :
                     (pick < 26) ? K_INS_POS   :
                     (pick < 45) ? K_READ      : K_DELETE;
        end
        return r;
    endfunction

    // Offer one request and hold it until the transfer happens.
    task automatic send_request(req_t r);
        s_valid <= 1'b1;
        s_data  <= r;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        requests_sent++;
    endtask

    // Receiver: changing stall patterns, plus one long hold-off while requests keep coming.
    initial begin : result_sink
        int unsigned mode;
        int unsigned tick;
        bit          held_off;
        m_ready  = 1'b0;
        held_off = 1'b0;
        tick     = 0;
        while (aresetn !== 1'b1) begin
            @(posedge aclk);
        end
        forever begin
            if (!held_off && requests_sent >= HOLD_AT) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 60)) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 == 0);
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus: directed corner cases, then random bursts, then the verdict.
    initial begin : stimulus
        req_t        directed [$];
        req_t        r;
        int unsigned total;
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        int unsigned j;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        requests_sent = 0;

        // Empty list: read, delete and insert past the end all miss.
        directed.push_back(make_request(K_READ, 0, 32'd0));
        directed.push_back(make_request(K_DELETE, 0, 32'd0));
        directed.push_back(make_request(K_INS_POS, 1, 32'h1234_5678));
        // Fill with extreme values; the position is ignored for front and end inserts.
        directed.push_back(make_request(K_INS_FRONT, 31, 32'h7FFF_FFFF));
        directed.push_back(make_request(K_INS_END, 31, 32'h8000_0000));
        directed.push_back(make_request(K_INS_POS, 1, 32'hFFFF_FFFF));
        directed.push_back(make_request(K_INS_POS, 0, 32'h0000_0000));
        // Insert at the current count appends; one past it is out of range.
        directed.push_back(make_request(K_INS_POS, 4, 32'hAAAA_AAAA));
        directed.push_back(make_request(K_INS_POS, 6, 32'h5555_5555));
        for (j = 0; j < 5; j++) begin
            directed.push_back(make_request(K_READ, j, 32'hFFFF_FFFF));
        end
        directed.push_back(make_request(K_READ, 5, 32'd0));
        directed.push_back(make_request(K_READ, 31, 32'd0));
        directed.push_back(make_request(K_DELETE, 2, 32'd0));
        directed.push_back(make_request(K_DELETE, 4, 32'd0));
        directed.push_back(make_request(K_DELETE, 31, 32'd0));
        // Undefined operations answer out of range and change nothing.
        directed.push_back(make_request(K_UNDEF_FIRST, 0, 32'hDEAD_BEEF));
        directed.push_back(make_request(K_UNDEF_FIRST + 3'd1, 1, 32'd7));
        directed.push_back(make_request(K_UNDEF_LAST, 31, 32'hFFFF_FFFF));
        directed.push_back(make_request(K_READ, 1, 32'd0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        total = directed.size() + RANDOM_REQS;
        idx   = 0;
        while (idx < total) begin
            burst = $urandom_range(1, 12);
            for (j = 0; j < burst && idx < total; j++) begin
                if (idx < directed.size()) begin
                    r = directed[idx];
                end else begin
                    r = random_request(((idx / PHASE_LEN) % 2) == 0);
                end
                send_request(r);
                idx++;
            end
            // A gap of zero keeps valid high straight into the next burst.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // Let the checker count the last request transfer before asking what it still owes.
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
